// File: sv/dahpq_pkg.sv
// Shared constants and the priority compare function for the d-ary heap priority queue.
// No dependencies.
package dahpq_pkg;

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;
   localparam logic [1:0] KIND_BUILD = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Strict priority compare, shared by every sift step.
   function automatic logic outranks(input logic order, input logic signed [31:0] a,
                                     input logic signed [31:0] b);
      logic r;
      begin
         r = order ? (a > b) : (a < b);
         return r;
      end
   endfunction

endpackage

// File: sv/d_ary_heap_priority_queue.sv
// Top level of the d-ary heap priority queue: sequencer, compare unit, result register.
// Depends on dahpq_pkg and dahpq_store.
//
// Channel  Direction  Words carried
// req_     in         kind, value
// rsp_     out        popped_value, status, entry_count, top_value, is_empty
// csr_     in         heap_order
//
// One item at a time. Every memory read goes through the single read port of the
// store, so a sink level reads the children one after another, then picks the winner
// and moves it up, then places the moving word. A pop reads the root and the last
// entry and sinks from the root, a push climbs a level at a time, and a build sinks
// each inner node in turn. Reset clears the count and order; store contents need no
// clearing because only entries below the count are read. A result waits in its
// register until taken; req_ready is low from acceptance until the result is taken.
module d_ary_heap_priority_queue #(
   parameter int CAPACITY = 1024,
   parameter int ARITY    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_popped_value,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_entry_count,
   output logic signed [31:0] rsp_top_value,
   output logic        rsp_is_empty,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_heap_order
);
   import dahpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   // Position math must hold the last child index of the deepest node.
   localparam int NW = $clog2(ARITY * CAPACITY + 2);
   localparam int KW = $clog2(ARITY + 1);

   // Division by ARITY is done as a multiply by a rounded-up reciprocal, which is exact
   // for every operand below 2**NW.
   localparam int DSH = NW + $clog2(ARITY);
   localparam int PW  = NW + DSH;
   localparam logic [DSH-1:0] ARITY_RCP =
      DSH'(((longint'(1) << DSH) + longint'(ARITY) - longint'(1)) / longint'(ARITY));

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_RD  = 4'd1;  // read parent
   localparam logic [3:0] S_UP_CMP = 4'd2;  // compare node with parent
   localparam logic [3:0] S_POP_RD = 4'd3;  // read root
   localparam logic [3:0] S_POP_WR = 4'd4;  // latch popped root, read last entry
   localparam logic [3:0] S_DN_RDP = 4'd5;  // read sink node
   localparam logic [3:0] S_DN_CAP = 4'd6;  // latch node value
   localparam logic [3:0] S_DN_CH  = 4'd7;  // scan children
   localparam logic [3:0] S_DN_SW  = 4'd8;  // swap with best child
   localparam logic [3:0] S_BLD    = 4'd9;  // next build node
   localparam logic [3:0] S_TOP_RD = 4'd10; // read root for the result
   localparam logic [3:0] S_TOP    = 4'd11;
   localparam logic [3:0] S_RSP    = 4'd12;
   localparam logic [3:0] S_DN_PUT     = 4'd13; // place moving node at new spot
   localparam logic [3:0] S_UP_WR_NEXT = 4'd14; // place pushed node one level up

   logic [3:0] state_ff, state_in;
   logic       order_ff, order_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] pos_ff, pos_in;         // node being moved
   logic [NW-1:0] best_ff, best_in;       // best position so far
   logic [NW-1:0] bld_ff, bld_in;         // next build node plus one
   logic [KW-1:0] ci_ff, ci_in;           // child scan index
   logic          ci_rd_ff, ci_rd_in;     // read of a child outstanding
   logic          build_ff, build_in;
   logic signed [31:0] node_ff, node_in;  // value of moving node
   logic signed [31:0] bval_ff, bval_in;  // best value so far
   logic signed [31:0] pop_ff, pop_in;
   logic [1:0]    status_ff, status_in;
   logic signed [31:0] top_ff, top_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;
   logic [NW-1:0] parent, first, child, next_child;
   logic [NW-1:0] cnt_n;
   logic [NW-1:0] div_arg, div_res;
   logic [PW-1:0] div_prod;

   dahpq_store #(.CAPACITY(CAPACITY)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign cnt_n  = NW'(count_ff);

   // The one divider serves the build start point when idle and the parent otherwise.
   assign div_arg  = (state_ff == S_IDLE) ? NW'(cnt_n - NW'(2)) : NW'(pos_ff - NW'(1));
   assign div_prod = PW'(div_arg) * PW'(ARITY_RCP);
   assign div_res  = NW'(div_prod >> DSH);

   assign parent     = div_res;
   assign first      = NW'(pos_ff * NW'(ARITY) + NW'(1));
   assign child      = NW'(first + NW'(ci_ff));
   assign next_child = NW'(child + NW'(1));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_popped_value = pop_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = 11'(count_ff);
   assign rsp_top_value    = top_ff;
   assign rsp_is_empty     = (count_ff == '0);

   always_comb begin
      state_in  = state_ff;
      order_in  = order_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      best_in   = best_ff;
      bld_in    = bld_ff;
      ci_in     = ci_ff;
      ci_rd_in  = 1'b0;
      build_in  = build_ff;
      node_in   = node_ff;
      bval_in   = bval_ff;
      pop_in    = pop_ff;
      status_in = status_ff;
      top_in    = top_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = node_ff;
      rd_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               order_in = csr_heap_order;
            end
            if (req_valid) begin
               pop_in    = '0;
               status_in = STATUS_OK;
               build_in  = 1'b0;
               state_in  = S_TOP_RD;
               case (req_kind)
                  KIND_PUSH, KIND_LOAD: begin
                     if (cnt_n >= NW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                        pos_in   = cnt_n;
                        node_in  = req_value;
                        if (req_kind == KIND_PUSH) begin
                           state_in = S_UP_RD;
                        end
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        state_in = S_POP_RD;
                     end
                  end
                  default: begin
                     if (count_ff > CW'(1)) begin
                        build_in = 1'b1;
                        bld_in   = NW'(div_res + NW'(1));
                        state_in = S_BLD;
                     end
                  end
               endcase
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = S_TOP_RD;
            end else begin
               rd_addr  = parent[AW-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (outranks(order_ff, node_ff, rd_data)) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = S_UP_WR_NEXT;
            end else begin
               state_in = S_TOP_RD;
            end
         end
         S_POP_RD: begin
            // root read for popped value, then last entry
            rd_addr  = '0;
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            pop_in   = rd_data;
            rd_addr  = count_ff[AW-1:0];
            pos_in   = '0;
            state_in = S_DN_CAP;
         end
         S_DN_RDP: begin
            rd_addr  = pos_ff[AW-1:0];
            state_in = S_DN_CAP;
         end
         S_DN_CAP: begin
            // in the pop path rd_data is the last entry, written to the root here
            node_in  = rd_data;
            bval_in  = rd_data;
            best_in  = pos_ff;
            ci_in    = '0;
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = rd_data;
            if (first >= cnt_n) begin
               state_in = build_ff ? S_BLD : S_TOP_RD;
            end else begin
               rd_addr  = first[AW-1:0];
               ci_rd_in = 1'b1;
               state_in = S_DN_CH;
            end
         end
         S_DN_CH: begin
            if (ci_rd_ff) begin
               if (outranks(order_ff, rd_data, bval_ff)) begin
                  bval_in = rd_data;
                  best_in = child;
               end
               ci_in = ci_ff + KW'(1);
               if (ci_ff + KW'(1) < KW'(ARITY) && next_child < cnt_n) begin
                  rd_addr  = next_child[AW-1:0];
                  ci_rd_in = 1'b1;
               end else begin
                  state_in = S_DN_SW;
               end
            end
         end
         S_DN_SW: begin
            if (best_ff == pos_ff) begin
               state_in = build_ff ? S_BLD : S_TOP_RD;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = bval_ff;
               pos_in   = best_ff;
               state_in = S_DN_PUT;
            end
         end
         S_DN_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = node_ff;
            bval_in  = node_ff;
            best_in  = pos_ff;
            ci_in    = '0;
            if (first >= cnt_n) begin
               state_in = build_ff ? S_BLD : S_TOP_RD;
            end else begin
               rd_addr  = first[AW-1:0];
               ci_rd_in = 1'b1;
               state_in = S_DN_CH;
            end
         end
         S_UP_WR_NEXT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = node_ff;
            state_in = S_UP_RD;
         end
         S_BLD: begin
            if (bld_ff == '0) begin
               state_in = S_TOP_RD;
            end else begin
               pos_in   = bld_ff - NW'(1);
               bld_in   = bld_ff - NW'(1);
               state_in = S_DN_RDP;
            end
         end
         S_TOP_RD: begin
            rd_addr  = '0;
            state_in = S_TOP;
         end
         S_TOP: begin
            top_in   = (count_ff == '0) ? '0 : rd_data;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         order_ff <= 1'b0;
         count_ff <= '0;
         build_ff <= 1'b0;
         ci_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         count_ff <= count_in;
         build_ff <= build_in;
         ci_rd_ff <= ci_rd_in;
      end
      pos_ff    <= pos_in;
      best_ff   <= best_in;
      bld_ff    <= bld_in;
      ci_ff     <= ci_in;
      node_ff   <= node_in;
      bval_ff   <= bval_in;
      pop_ff    <= pop_in;
      status_ff <= status_in;
      top_ff    <= top_in;
   end

   // The count never exceeds capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");

   // A result held back by the consumer keeps its top value and entry count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_entry_count)) else $error("result changed while stalled");

   // An empty-heap status never comes with a popped value.
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_popped_value == 0)
      else $error("underflow carries a value");

   // No new item while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open while result pending");
endmodule

// File: sv/dahpq_store.sv
// Heap storage memory: one write port, one registered read port.
// Depends on nothing.
module dahpq_store #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [31:0]                 wr_data,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [31:0]                 rd_data
);
   logic [31:0] mem [CAPACITY];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: tb/tb.sv
// Testbench for the d-ary heap priority queue: directed and random words with a
// built-in predictor of the heap. Depends on dahpq_pkg and d_ary_heap_priority_queue.
`timescale 1ns / 100ps

module tb;
   import dahpq_pkg::*;

   localparam int SLOTS      = 1024;
   localparam int FANOUT     = 4;
   localparam int CYCLE_CAP  = 3000000;
   localparam int LONG_HOLD  = 400;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } heap_cmd_t;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [10:0]        entry_count;
      logic signed [31:0] top_value;
      logic               is_empty;
   } heap_reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_PUSH;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_popped_value;
   logic [1:0]         rsp_status;
   logic [10:0]        rsp_entry_count;
   logic signed [31:0] rsp_top_value;
   logic               rsp_is_empty;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_heap_order = 1'b0;

   // Words waiting to be sent, and replies predicted but not yet seen.
   heap_cmd_t   pending_cmds[$];
   heap_reply_t awaited_replies[$];

   // Shadow copy of the heap contents, count and ordering.
   logic signed [31:0] shadow_heap [0:SLOTS-1];
   int                 shadow_count = 0;
   logic               shadow_order = 1'b0;

   int  error_count   = 0;
   int  replies_seen  = 0;
   int  cycle_count   = 0;
   int  idle_percent  = 25;
   bit  calm          = 1'b0;
   int  send_gap      = 0;
   int  recv_stall    = 0;
   int  recv_hold     = 0;
   bit  hold_done     = 1'b0;

   d_ary_heap_priority_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_top_value    (rsp_top_value),
      .rsp_is_empty     (rsp_is_empty),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_heap_order   (csr_heap_order)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Strict priority under the shadow ordering: min-first or max-first.
   function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b);
      return shadow_order ? (a > b) : (a < b);
   endfunction

   function automatic void swap_slots(int x, int y);
      logic signed [31:0] t;
      t = shadow_heap[x];
      shadow_heap[x] = shadow_heap[y];
      shadow_heap[y] = t;
   endfunction

   function automatic void climb(int pos);
      int parent;
      while (pos > 0) begin
         parent = (pos - 1) / FANOUT;
         if (!ranks_above(shadow_heap[pos], shadow_heap[parent])) break;
         swap_slots(pos, parent);
         pos = parent;
      end
   endfunction

   // Sinks one node; among equal children the first one wins.
   function automatic void descend(int pos, int n);
      int best;
      int first;
      int stop;
      forever begin
         best  = pos;
         first = FANOUT * pos + 1;
         if (first >= n) break;
         stop = (n - first > FANOUT) ? first + FANOUT : n;
         for (int c = first; c < stop; c++)
            if (ranks_above(shadow_heap[c], shadow_heap[best])) best = c;
         if (best == pos) break;
         swap_slots(pos, best);
         pos = best;
      end
   endfunction

   // Applies one accepted word to the shadow heap and returns the reply it must cause.
   function automatic heap_reply_t apply_heap_cmd(heap_cmd_t w);
      heap_reply_t r;
      r = '0;
      r.status = STATUS_OK;
      case (w.kind)
         KIND_PUSH, KIND_LOAD: begin
            if (shadow_count >= SLOTS) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_heap[shadow_count] = w.value;
               shadow_count++;
               if (w.kind == KIND_PUSH) climb(shadow_count - 1);
            end
         end
         KIND_POP: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped_value = shadow_heap[0];
               shadow_count--;
               shadow_heap[0] = shadow_heap[shadow_count];
               if (shadow_count > 0) descend(0, shadow_count);
            end
         end
         default: begin
            // Floyd heapify from the last inner node back to the root.
            if (shadow_count > 1)
               for (int i = (shadow_count - 2) / FANOUT + 1; i > 0; i--)
                  descend(i - 1, shadow_count);
         end
      endcase
      r.entry_count = shadow_count[10:0];
      r.top_value   = (shadow_count > 0) ? shadow_heap[0] : '0;
      r.is_empty    = (shadow_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch in %s at reply %0d: got %0d, want %0d", field, replies_seen,
               got, want);
      error_count++;
   endtask

   // Values mix the extremes, a narrow band that forces ties, and full-range noise.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3, 4: return $signed($urandom_range(16)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic void queue_cmd(logic [1:0] kind, logic signed [31:0] value);
      heap_cmd_t w;
      w.kind  = kind;
      w.value = value;
      pending_cmds.insert(pending_cmds.size(), w);
   endfunction

   // Driver: one word at a time, bursts of idle cycles between some words.
   always @(posedge clock) begin
      heap_cmd_t w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            awaited_replies.insert(awaited_replies.size(),
                                   apply_heap_cmd('{req_kind, req_value}));
         if (req_valid && !req_ready) begin
            // Word still on offer; keep it steady.
         end else if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            w = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_kind  <= w.kind;
            req_value <= w.value;
            if (!calm && $urandom_range(99) < idle_percent)
               send_gap <= $urandom_range(1, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each reply against the oldest prediction and throttles rsp_ready.
   always @(posedge clock) begin
      heap_reply_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected reply", 1, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_popped_value !== want.popped_value)
                  report_mismatch("popped_value", rsp_popped_value, want.popped_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
               if (rsp_top_value !== want.top_value)
                  report_mismatch("top_value", rsp_top_value, want.top_value);
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_is_empty, want.is_empty);
            end
            replies_seen++;
         end
         // One long hold-off so the block backs up and stalls its input.
         if (!hold_done && replies_seen == 300) begin
            hold_done <= 1'b1;
            recv_hold <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (!calm && $urandom_range(99) < idle_percent) begin
            recv_stall <= $urandom_range(0, 10);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Waits until every word has been sent and every reply has come back. The check is
   // made between rising edges so that the driver's updates have all settled.
   task automatic drain();
      while (pending_cmds.size() > 0 || awaited_replies.size() > 0 || req_valid)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(logic order);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_heap_order <= order;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      shadow_order = order;
      csr_valid <= 1'b0;
   endtask

   // Random phase: mostly well-formed traffic, with the heap kept small by
   // leaning on pops once it grows.
   task automatic random_phase(int words);
      int est;
      int roll;
      est = shadow_count;
      for (int k = 0; k < words; k++) begin
         roll = $urandom_range(99);
         if (est > 40) roll = (roll < 60) ? 50 : roll;
         if (roll < 30) begin
            queue_cmd(KIND_PUSH, pick_value());
            est++;
         end else if (roll < 45) begin
            queue_cmd(KIND_LOAD, pick_value());
            est++;
         end else if (roll < 90) begin
            queue_cmd(KIND_POP, $signed($urandom));
            if (est > 0) est--;
         end else begin
            queue_cmd(KIND_BUILD, $signed($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, min-first: empty cases, extreme values, every kind.
      write_order(1'b0);
      queue_cmd(KIND_POP, 32'sh7fff_ffff);
      queue_cmd(KIND_BUILD, 0);
      queue_cmd(KIND_PUSH, 32'sh7fff_ffff);
      queue_cmd(KIND_BUILD, 0);
      queue_cmd(KIND_PUSH, 32'sh8000_0000);
      queue_cmd(KIND_PUSH, 0);
      queue_cmd(KIND_PUSH, -1);
      queue_cmd(KIND_LOAD, -5);
      queue_cmd(KIND_LOAD, 5);
      queue_cmd(KIND_LOAD, 32'sh8000_0000);
      queue_cmd(KIND_BUILD, -1);
      queue_cmd(KIND_POP, 0);
      queue_cmd(KIND_POP, 0);
      queue_cmd(KIND_POP, 0);
      queue_cmd(KIND_PUSH, 3);
      drain();

      // Order flipped with entries stored: pops use the new compare, build repairs.
      write_order(1'b1);
      queue_cmd(KIND_POP, 0);
      queue_cmd(KIND_PUSH, 9);
      queue_cmd(KIND_BUILD, 0);
      queue_cmd(KIND_POP, 0);
      for (int k = 0; k < 5; k++) queue_cmd(KIND_POP, 0);
      drain();

      idle_percent = 30;
      random_phase(200);
      drain();
      write_order(1'b0);
      idle_percent = 0;
      random_phase(150);
      drain();
      write_order(1'b1);
      idle_percent = 60;
      random_phase(200);
      drain();
      write_order(1'b0);

      // Last part: fill to capacity with no idling, overflow, heapify, drain partly.
      calm = 1'b1;
      idle_percent = 20;
      while (shadow_count > 0) begin
         queue_cmd(KIND_POP, 0);
         drain();
      end
      for (int k = 0; k < SLOTS + 3; k++) queue_cmd(KIND_LOAD, pick_value());
      queue_cmd(KIND_PUSH, 32'sh8000_0000);
      queue_cmd(KIND_BUILD, 0);
      for (int k = 0; k < 30; k++) queue_cmd(KIND_POP, 0);
      queue_cmd(KIND_PUSH, 32'sh8000_0000);
      queue_cmd(KIND_PUSH, 32'sh7fff_ffff);
      drain();
      write_order(1'b1);
      queue_cmd(KIND_BUILD, 0);
      for (int k = 0; k < 30; k++) queue_cmd(KIND_POP, 0);
      drain();

      repeat (200) @(posedge clock);
      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/dahpq_pkg.sv
sv/dahpq_store.sv
sv/d_ary_heap_priority_queue.sv
tb/tb.sv
